// ===== sv/utf8_to_utf16_converter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// utf8 to utf16 converter assertion macros
// shared concurrent assertion forms for the converter checker
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_CONVERTER_UNIT_ASSERT_SVH
`define UTF8_TO_UTF16_CONVERTER_UNIT_ASSERT_SVH

// condition checked at every clock edge outside reset
`define U8U16_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define U8U16_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/utf8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8u16_pkg
// shared types, constants and decode helpers of the utf8 to utf16 converter
// ----------------------------------------------------------------------------
package utf8u16_pkg;

  localparam logic [15:0] ReplacementUnit = 16'hFFFD;
  localparam logic [15:0] HighSurrBase    = 16'hD800;
  localparam logic [15:0] LowSurrBase     = 16'hDC00;
  localparam logic [20:0] SupplementBase  = 21'h10000;
  localparam logic [15:0] LowTenMask      = 16'h03FF;
  localparam logic [7:0]  PayloadMask     = 8'h3F;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
  } out_word_t;

  // one closed run of 1 to 4 bytes
  typedef struct packed {
    logic [3:0][7:0] run_bytes;
    logic [2:0]      count;
    logic            whole;     // run holds the full length its lead asks for
  } run_t;

  // decoded units of one run, 1 to 3 of them
  typedef struct packed {
    logic [2:0][15:0] units;
    logic [1:0]       count;
  } decoded_t;

  function automatic logic [2:0] lead_length(input logic [7:0] c);
    logic [2:0] len;
    if (!c[7]) begin
      len = 3'd1;
    end else if (c[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // byte decoded on its own: ascii passes, anything else is replaced
  function automatic logic [15:0] single_unit(input logic [7:0] c);
    return c[7] ? ReplacementUnit : {8'h00, c};
  endfunction

  function automatic logic [5:0] payload(input logic [7:0] c);
    logic [7:0] m;
    m = c & PayloadMask;
    return m[5:0];
  endfunction

endpackage

// ===== sv/utf8u16_assembler.sv =====
// ----------------------------------------------------------------------------
// utf8u16_assembler
// collects lead and following bytes and closes a run into the run register
// ----------------------------------------------------------------------------
module utf8u16_assembler (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  utf8u16_pkg::in_word_t in_word_i,
  input  logic                  run_take_i,
  output logic                  run_valid_o,
  output utf8u16_pkg::run_t     run_o
);

  logic [2:0][7:0]   held_q;
  logic [1:0]        held_count_q;
  logic [2:0]        needed_q;
  logic              run_valid_q;
  utf8u16_pkg::run_t run_q;
  utf8u16_pkg::run_t run_d;
  logic [2:0]        need_now;
  logic [2:0]        count_now;
  logic              complete;

  assign need_now  = (held_count_q == 2'd0) ? utf8u16_pkg::lead_length(in_word_i.in_byte)
                                            : needed_q;
  assign count_now = {1'b0, held_count_q} + 3'd1;
  assign complete  = in_word_i.end_of_text || (count_now >= need_now);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      run_d.run_bytes[i] = (held_count_q == 2'(i)) ? in_word_i.in_byte : held_q[i];
    end
    run_d.run_bytes[3] = in_word_i.in_byte;
    run_d.count        = count_now;
    run_d.whole        = (count_now >= need_now);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= 2'd0;
      needed_q     <= 3'd0;
      run_valid_q  <= 1'b0;
    end else begin
      if (accept_i) begin
        if (complete) begin
          held_count_q <= 2'd0;
          needed_q     <= 3'd0;
        end else begin
          held_count_q <= count_now[1:0];
          needed_q     <= need_now;
        end
      end
      run_valid_q <= (run_valid_q && !run_take_i) || (accept_i && complete);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !complete) begin
      held_q[held_count_q] <= in_word_i.in_byte;
    end
    if (accept_i && complete) begin
      run_q <= run_d;
    end
  end

  assign run_valid_o = run_valid_q;
  assign run_o       = run_q;

endmodule

// ===== sv/utf8u16_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8u16_decoder
// turns one closed run into its utf16 code units
// ----------------------------------------------------------------------------
module utf8u16_decoder (
  input  utf8u16_pkg::run_t     run_i,
  output utf8u16_pkg::decoded_t dec_o
);

  logic [3:0][7:0] b;
  logic [20:0]     cp;
  logic [20:0]     v;
  logic [2:0]      tail_len;

  assign b        = run_i.run_bytes;
  assign cp       = {b[0][2:0], utf8u16_pkg::payload(b[1]), utf8u16_pkg::payload(b[2]),
                     utf8u16_pkg::payload(b[3])};
  assign v        = cp - utf8u16_pkg::SupplementBase;
  assign tail_len = utf8u16_pkg::lead_length(b[1]);

  always_comb begin
    dec_o.units = {3{utf8u16_pkg::ReplacementUnit}};
    dec_o.count = 2'd1;
    case (run_i.count)
      3'd1: begin
        dec_o.units[0] = utf8u16_pkg::single_unit(b[0]);
      end
      3'd2: begin
        if (run_i.whole) begin
          dec_o.units[0] = {5'b0, b[0][4:0], utf8u16_pkg::payload(b[1])};
        end else begin
          // cut short: lead replaced, next byte alone
          dec_o.units[1] = utf8u16_pkg::single_unit(b[1]);
          dec_o.count    = 2'd2;
        end
      end
      3'd3: begin
        if (run_i.whole) begin
          dec_o.units[0] = {b[0][3:0], utf8u16_pkg::payload(b[1]),
                            utf8u16_pkg::payload(b[2])};
        end else if (tail_len == 3'd1) begin
          dec_o.units[1] = utf8u16_pkg::single_unit(b[1]);
          dec_o.units[2] = utf8u16_pkg::single_unit(b[2]);
          dec_o.count    = 2'd3;
        end else if (tail_len == 3'd2) begin
          // the two held followers form a two-byte sequence
          dec_o.units[1] = {5'b0, b[1][4:0], utf8u16_pkg::payload(b[2])};
          dec_o.count    = 2'd2;
        end else begin
          dec_o.units[2] = utf8u16_pkg::single_unit(b[2]);
          dec_o.count    = 2'd3;
        end
      end
      3'd4: begin
        if (cp >= utf8u16_pkg::SupplementBase) begin
          dec_o.units[0] = utf8u16_pkg::HighSurrBase + {5'b0, v[20:10]};
          dec_o.units[1] = utf8u16_pkg::LowSurrBase + (v[15:0] & utf8u16_pkg::LowTenMask);
          dec_o.count    = 2'd2;
        end else begin
          dec_o.units[0] = cp[15:0];
        end
      end
      default: begin
        dec_o.count = 2'd1;
      end
    endcase
  end

endmodule

// ===== sv/utf8u16_unit_queue.sv =====
// ----------------------------------------------------------------------------
// utf8u16_unit_queue
// result register holding the units of one run, sent out one per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module utf8u16_unit_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   run_valid_i,
  input  utf8u16_pkg::decoded_t  dec_i,
  output logic                   run_take_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output utf8u16_pkg::out_word_t out_word_o
);

  logic [2:0][15:0] units_q;
  logic [1:0]       left_q;
  logic             take;
  logic             load;

  assign out_valid_o = (left_q != 2'd0);
  assign take        = out_valid_o && !out_stall_i;
  assign load        = run_valid_i && ((left_q == 2'd0) || ((left_q == 2'd1) && take));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 2'd0;
    end else if (load) begin
      left_q <= dec_i.count;
    end else if (take) begin
      left_q <= left_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      units_q <= dec_i.units;
    end else if (take) begin
      units_q <= {units_q[2], units_q[2], units_q[1]};
    end
  end

  assign run_take_o           = load;
  assign out_word_o.code_unit = units_q[0];
  assign out_word_o.run_last  = (left_q == 2'd1);

endmodule

// ===== sv/utf8_to_utf16_converter_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_converter_unit
// streaming utf8 to utf16 transcoder, when not stalled one byte in, one code unit out per cycle
// ----------------------------------------------------------------------------
// The converter takes one byte of utf8 text per accepted word and returns
// utf16 code units, with run_last marking the final unit caused by a byte.
// Bytes that open or continue a sequence give no output; the byte that closes
// a sequence (or carries end_of_text) gives one to three units. A byte that
// closes a run is written into the run register, where it is decoded; its
// units then go into the result register of the unit queue, from which they
// leave one per cycle while the output is not stalled. Sustained rate is one
// byte per cycle as long as each closing byte yields a single unit and the
// output is not stalled; a run with n units holds the output until all n
// units are taken, and the input stalls only while the next closed run waits
// in the run register for the unit queue to drain. Following bytes are taken
// as 6-bit payload without checking their top bits, an invalid lead gives
// 0xFFFD, and text ending inside a sequence replaces the lead and decodes the
// held bytes after it alone or, where they form a two-byte sequence, as one.
// ----------------------------------------------------------------------------
module utf8_to_utf16_converter_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // byte side
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  utf8u16_pkg::in_word_t  in_word_i,
  // code unit side
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output utf8u16_pkg::out_word_t out_word_o
);

  utf8u16_pkg::run_t     run;
  utf8u16_pkg::decoded_t dec;
  logic                  run_valid;
  logic                  run_take;
  logic                  accept;

  // a closed run parked in the run register blocks new bytes until the
  // queue can take it (empty, or its last unit leaves this cycle)
  assign in_stall_o = run_valid && !run_take;
  assign accept     = in_valid_i && !in_stall_o;

  // sequence assembly and run register
  utf8u16_assembler u_assembler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_word_i   (in_word_i),
    .run_take_i  (run_take),
    .run_valid_o (run_valid),
    .run_o       (run)
  );

  // single-pass decode of the run register
  utf8u16_decoder u_decoder (
    .run_i (run),
    .dec_o (dec)
  );

  // result register, drains one unit per cycle while the output is not stalled
  utf8u16_unit_queue u_unit_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (run_valid),
    .dec_i       (dec),
    .run_take_o  (run_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== sv/utf8u16_checker.sv =====
// ----------------------------------------------------------------------------
// utf8u16_checker
// port-level assertions for the utf8 to utf16 converter, bound to the top
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_converter_unit_assert.svh"

module utf8u16_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input utf8u16_pkg::out_word_t out_word_o
);

  localparam logic [5:0] HighSurrTag = 6'b110110;
  localparam logic [5:0] LowSurrTag  = 6'b110111;

  logic        out_take;
  logic        mid_run;
  logic        pair_start;
  logic        low_ready;
  logic        out_held;
  logic [16:0] out_view;

  assign out_take   = out_valid_o && !out_stall_i;
  assign mid_run    = out_take && !out_word_o.run_last;
  assign pair_start = mid_run && (out_word_o.code_unit[15:10] == HighSurrTag);
  assign low_ready  = out_valid_o && (out_word_o.code_unit[15:10] == LowSurrTag);
  assign out_held   = out_valid_o && out_stall_i;
  assign out_view   = {out_word_o.code_unit, out_valid_o};

  // input only backs up behind pending output
  `U8U16_ASSERT(a_stall_pending, clk_i, rst_ni, !in_stall_o || out_valid_o, "input stalled idle")

  // units of one byte are offered without a gap
  `U8U16_ASSERT_NEXT(a_run_contiguous, clk_i, rst_ni, mid_run, out_valid_o, "gap inside a run")

  // a high surrogate that is not last is followed by its low half
  `U8U16_ASSERT_NEXT(a_pair_order, clk_i, rst_ni, pair_start, low_ready, "pair out of order")

  // stalled output holds
  `U8U16_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, $stable(out_view), "held word changed")

  // run_last of a stalled word holds as well
  `U8U16_ASSERT_NEXT(a_last_hold, clk_i, rst_ni, out_held, $stable(out_word_o.run_last), "run_last moved")

endmodule

bind utf8_to_utf16_converter_unit utf8u16_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
